[src/pql_pkg.sv]
package pql_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic func;
		logic signed [31:0] item_value;
		logic [7:0] item_priority;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [7:0] out_priority;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic shift_start;
		logic shift;
		logic finish;
		logic load_out;
	} pql_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic shift_done;
		logic out_free;
	} pql_sts_t;

endpackage

[src/pql_datapath.sv]
module pql_datapath
	import pql_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pql_cmd_t  cmd,
	output pql_sts_t  sts,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	logic signed [31:0] mem_val [QUEUE_DEPTH];
	logic [7:0]         mem_pri [QUEUE_DEPTH];

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic signed [31:0] rd_val_s1;
	logic [7:0]         rd_pri_s1;
	logic               first_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic signed [31:0] best_val_q;
	logic [7:0]         best_pri_q;
	out_item_t          res_q;
	out_item_t          rsp_q;
	logic               out_valid_q;

	logic               issue;
	logic               do_insert;
	logic               shift_wr;
	logic               we;
	logic [IDX_W-1:0]   wr_addr;
	logic signed [31:0] wr_val;
	logic [7:0]         wr_pri;
	logic               take_best;

	always_comb begin
		issue = (cmd.scan || cmd.shift) && (ptr_q < count_q);
		do_insert = cmd.accept && (req.func == FUNC_INSERT)
			&& (count_q < CNT_W'(QUEUE_DEPTH));
		shift_wr = cmd.shift && rd_vld_s1;
		we = do_insert || shift_wr;
		// A shifted entry moves down by one place, behind the read pointer.
		wr_addr = shift_wr ? (rd_idx_s1 - IDX_W'(1)) : count_q[IDX_W-1:0];
		wr_val = shift_wr ? rd_val_s1 : req.item_value;
		wr_pri = shift_wr ? rd_pri_s1 : req.item_priority;
		take_best = cmd.scan && rd_vld_s1 && (first_q || (rd_pri_s1 > best_pri_q));
	end

	always_comb begin
		sts.need_scan = (req.func == FUNC_EXTRACT) && (count_q != '0);
		sts.scan_done = (ptr_q == count_q) && !rd_vld_s1;
		sts.shift_done = (ptr_q == count_q) && !rd_vld_s1;
		sts.out_free = !out_valid_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_val[wr_addr] <= wr_val;
			mem_pri[wr_addr] <= wr_pri;
		end
		if (issue) begin
			rd_val_s1 <= mem_val[ptr_q[IDX_W-1:0]];
			rd_pri_s1 <= mem_pri[ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			first_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_idx_s1 <= ptr_q[IDX_W-1:0];
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (take_best) begin
				first_q <= 1'b0;
			end
			if (cmd.accept) begin
				ptr_q <= '0;
				first_q <= 1'b1;
				if (do_insert) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.shift_start) begin
				ptr_q <= CNT_W'(best_idx_q) + CNT_W'(1);
			end
			if (cmd.finish) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_best) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= rd_val_s1;
			best_pri_q <= rd_pri_s1;
		end
		if (cmd.accept) begin
			res_q.out_value <= '0;
			res_q.out_priority <= '0;
			if (req.func == FUNC_INSERT) begin
				res_q.status <= do_insert ? STATUS_OK : STATUS_FULL;
			end else begin
				res_q.status <= STATUS_EMPTY;
			end
		end
		if (cmd.finish) begin
			res_q.out_value <= best_val_q;
			res_q.out_priority <= best_pri_q;
			res_q.status <= STATUS_OK;
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CNT_W'(rd_idx_s1) < count_q))
		else $error("read of an entry beyond the fill count");

	a_shift_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && rd_vld_s1) |-> (rd_idx_s1 != '0))
		else $error("shift write address wraps below entry zero");

	a_finish_removes_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("extract did not remove exactly one entry");
`endif

endmodule

[src/pql_ctrl.sv]
module pql_ctrl
	import pql_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output pql_cmd_t cmd,
	input  pql_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		req_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.accept = req_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.shift_start = sts.scan_done;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				cmd.finish = sts.shift_done;
			end
			ST_FINISH: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= sts.need_scan ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (sts.shift_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/priority_queue_list_unit.sv]
// Insert, and extract from an empty queue: the accepted item goes straight to the finish state, and its
// result is registered there once the output register is free. Extract from a non-empty queue runs
// a scan over the entry store, then a shift of later entries down.
// One item is in work at a time; the next is accepted the cycle after its result is registered.
// A registered result may wait for the consumer while the next item is already accepted.
// Reset (arst_n low) empties the queue at once; the entry store itself is not cleared.
module priority_queue_list_unit
	import pql_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	pql_cmd_t cmd;
	pql_sts_t sts;

	pql_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pql_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[test/tb_priority_queue_list_unit.sv]
module tb_priority_queue_list_unit
	import pql_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1880;
	localparam int QUIET_TAIL = 300;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_CAP = 50;

	typedef struct {
		in_item_t  cmd;
		logic      fixed;
		out_item_t want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp;

	// Shadow copy of the queue contents, kept in insertion order.
	logic signed [31:0] held_value [QUEUE_DEPTH];
	logic [7:0]         held_priority [QUEUE_DEPTH];
	int                 held_count = 0;

	out_item_t pending_results [$];
	plan_row_t plan [$];
	out_item_t head_result;
	logic      idle_on = 1'b1;
	int        stall_left = 0;
	int        mismatches = 0;
	int        stuck_cycles = 0;

	priority_queue_list_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic out_item_t serve_request(in_item_t x);
		out_item_t r;
		int best;
		r = '0;
		if (x.func == FUNC_INSERT) begin
			if (held_count >= QUEUE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				held_value[held_count] = x.item_value;
				held_priority[held_count] = x.item_priority;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			// Strict compare keeps the earliest entry on a tie.
			best = 0;
			for (int i = 1; i < held_count; i++) begin
				if (held_priority[i] > held_priority[best]) begin
					best = i;
				end
			end
			r.out_value = held_value[best];
			r.out_priority = held_priority[best];
			for (int i = best; i + 1 < held_count; i++) begin
				held_value[i] = held_value[i + 1];
				held_priority[i] = held_priority[i + 1];
			end
			held_count--;
		end
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < REPORT_CAP) begin
			$display("%0t mismatch %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	task automatic add_row(logic f, logic [31:0] v, logic [7:0] p, logic fixed,
			logic [1:0] st);
		plan_row_t row;
		row.cmd = '{func: f, item_value: v, item_priority: p};
		row.fixed = fixed;
		row.want = '{out_value: 32'sd0, out_priority: 8'd0, status: st};
		plan.push_back(row);
	endtask

	// Holds the item on the bus until it is taken, then records its result.
	task automatic send_item(in_item_t x, logic fixed, out_item_t want);
		out_item_t predicted;
		req_valid <= 1'b1;
		req <= x;
		do @(posedge clk); while (!req_ready);
		predicted = serve_request(x);
		pending_results.push_back(fixed ? want : predicted);
	endtask

	task automatic maybe_pause();
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 9);
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					note_mismatch("unexpected result item", rsp.out_value, 32'd0);
				end else begin
					head_result = pending_results.pop_front();
					if (rsp.out_value !== head_result.out_value)
						note_mismatch("out_value", rsp.out_value, head_result.out_value);
					if (rsp.out_priority !== head_result.out_priority)
						note_mismatch("out_priority", rsp.out_priority,
							head_result.out_priority);
					if (rsp.status !== head_result.status)
						note_mismatch("status", rsp.status, head_result.status);
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 8);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		in_item_t  item;
		out_item_t no_result;
		int        insert_pct;
		no_result = '0;
		insert_pct = 50;

		add_row(FUNC_EXTRACT, 32'h0000_0000, 8'd0, 1'b1, STATUS_EMPTY);
		add_row(FUNC_INSERT, 32'h7fff_ffff, 8'd0, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h8000_0000, 8'd255, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'hffff_ffff, 8'd255, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0000, 8'd128, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0001, 8'd0, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h1234_5678, 8'd7, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'hffff_fffe, 8'd255, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0037, 8'd1, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'haaaa_aaaa, 8'd170, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h5555_5555, 8'd85, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0003, 8'd254, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0004, 8'd254, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'hffff_ff9c, 8'd0, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0006, 8'd128, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0007, 8'd200, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0008, 8'd255, 1'b1, STATUS_OK);
		add_row(FUNC_INSERT, 32'h0000_0009, 8'd9, 1'b1, STATUS_FULL);
		// Extracts carry junk in the payload, which the block must ignore.
		repeat (4) add_row(FUNC_EXTRACT, 32'hdead_beef, 8'hff, 1'b0, STATUS_OK);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			maybe_pause();
			send_item(plan[i].cmd, plan[i].fixed, plan[i].want);
		end

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			idle_on <= (k < RANDOM_ITEMS - QUIET_TAIL) && ((k / 150) % 4 != 3);
			// Shift the insert/extract mix now and then so the queue swings
			// between empty and full.
			if (k % 60 == 0) begin
				case ($urandom_range(0, 4))
					0: insert_pct = 85;
					1: insert_pct = 15;
					2: insert_pct = 70;
					3: insert_pct = 30;
					default: insert_pct = 50;
				endcase
			end
			item.func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
			item.item_value = $urandom;
			case ($urandom_range(0, 3))
				0: item.item_priority = 8'($urandom_range(0, 3));
				1: item.item_priority = 8'($urandom_range(252, 255));
				default: item.item_priority = 8'($urandom_range(0, 255));
			endcase
			if (k == RANDOM_ITEMS / 2) begin
				req_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end else begin
				maybe_pause();
			end
			send_item(item, 1'b0, no_result);
		end

		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
